### rtl/prfr_pkg.sv
// ----------------------------------------------------------------------------
// prfr_pkg
// Types and constants shared by the pulse ratio frame receiver and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package prfr_pkg;

    typedef enum logic [1:0] {
        PH_PREAMBLE = 2'd0,
        PH_START    = 2'd1,
        PH_DATA     = 2'd2,
        PH_STOP     = 2'd3
    } t_phase;

    typedef enum logic {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_RATIO_LIMIT    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] high_time;
        logic [15:0] low_time;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_address;
        logic [7:0] frame_command;
        logic [7:0] frame_check;
        logic       crc_good;
        logic       address_good;
        logic       output_one_level;
        logic       output_two_level;
    } t_out_item;

    localparam int          CFG_DATA_W        = 8;
    localparam logic [7:0]  DEV_ADDR_RESET    = 8'h00;
    localparam logic [3:0]  RATIO_LIMIT_RESET = 4'd3;
    localparam logic [3:0]  START_MARK        = 4'hF;
    localparam logic [7:0]  CRC_POLY          = 8'h8C;
    localparam logic [7:0]  CMD_ONE           = 8'd1;
    localparam logic [7:0]  CMD_TWO           = 8'd2;
    localparam int          KEPT_BITS         = 24;
    localparam int          CRC_BITS          = 16;

    typedef logic [CRC_BITS-1:0][7:0] t_crc_tab;

    // CRC-8 of the two-byte message with only the bit at arrival position p set
    function automatic t_crc_tab crc_tab_build();
        t_crc_tab    tab;
        logic [7:0]  crc;
        logic [15:0] msg;
        logic        d;
        logic        mix;
        for (int p = 0; p < CRC_BITS; p++) begin
            msg = 16'h8000 >> p;
            crc = 8'h00;
            for (int k = 0; k < CRC_BITS; k++) begin
                d   = (k < 8) ? msg[8 + k] : msg[k - 8];
                mix = crc[0] ^ d;
                crc = crc >> 1;
                if (mix) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            tab[p] = crc;
        end
        return tab;
    endfunction

    localparam t_crc_tab CRC_TAB = crc_tab_build();

endpackage

`default_nettype wire

### rtl/pulse_ratio_frame_receiver_unit.sv
// A result is registered and valid in the cycle after the pulse that ends its frame.
// Throughput: one pulse per cycle unless a pending result is stalled; the result
// register frees its slot in the same cycle that the pending result is taken.
// Reset: synchronous, active low; clears the frame state except the byte shifter,
// both output levels and the result valid; resets the configuration registers.
// ----------------------------------------------------------------------------
// pulse_ratio_frame_receiver_unit
// Classifies measured pulses by their high/low ratio, tracks the preamble and
// start field, assembles a frame and checks its CRC-8 and address.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_ratio_frame_receiver_unit #(
    parameter int FRAME_BYTES = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire prfr_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output prfr_pkg::t_out_item                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [prfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int FRAME_BITS = 8 * FRAME_BYTES;
    localparam int CNT_W      = $clog2(FRAME_BITS);

    prfr_pkg::t_phase   r_phase, n_phase;
    logic               r_prev, n_prev;
    logic [3:0]         r_start, n_start;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [23:0]        r_bytes, n_bytes;
    logic [7:0]         r_crc, n_crc;
    logic               r_out1, n_out1;
    logic               r_out2, n_out2;
    logic [7:0]         r_dev_addr;
    logic [3:0]         r_ratio;
    logic               r_out_valid, n_out_valid;
    prfr_pkg::t_out_item r_out_data, n_out_data;

    logic               accept;
    logic               bit_val;
    logic [15:0]        big_t, small_t;
    logic [20:0]        limit_prod;
    logic               reject;
    logic [3:0]         start_next;
    logic               cg, ag;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign bit_val    = i_in_data.low_time > i_in_data.high_time;
    assign big_t      = bit_val ? i_in_data.low_time : i_in_data.high_time;
    assign small_t    = bit_val ? i_in_data.high_time : i_in_data.low_time;
    assign limit_prod = 21'({1'b0, r_ratio} + 5'd1) * {5'd0, small_t};
    assign reject     = (small_t == 16'd0) || ({5'd0, big_t} >= limit_prod);
    assign start_next = {r_start[2:0], bit_val};

    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_start     = r_start;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_crc       = r_crc;
        n_out1      = r_out1;
        n_out2      = r_out2;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        cg          = 1'b0;
        ag          = 1'b0;
        if (accept) begin
            if (reject) begin
                n_phase = prfr_pkg::PH_PREAMBLE;
                n_prev  = 1'b0;
                n_start = 4'd0;
                n_count = '0;
            end else begin
                unique case (r_phase)
                    prfr_pkg::PH_PREAMBLE: begin
                        if (r_prev != bit_val) begin
                            n_prev = bit_val;
                        end else if (!bit_val) begin
                            n_phase = prfr_pkg::PH_START;
                            n_start = 4'd0;
                        end else begin
                            n_prev  = 1'b0;
                            n_start = 4'd0;
                            n_count = '0;
                        end
                    end
                    prfr_pkg::PH_START: begin
                        n_start = start_next;
                        if (start_next[3]) begin
                            n_start = 4'd0;
                            n_prev  = 1'b0;
                            n_count = '0;
                            n_crc   = 8'h00;
                            if (start_next == prfr_pkg::START_MARK) begin
                                n_phase = prfr_pkg::PH_DATA;
                            end else begin
                                n_phase = prfr_pkg::PH_PREAMBLE;
                            end
                        end
                    end
                    prfr_pkg::PH_DATA: begin
                        if ({{(32-CNT_W){1'b0}}, r_count} < prfr_pkg::KEPT_BITS) begin
                            n_bytes = {r_bytes[22:0], bit_val};
                        end
                        if ({{(32-CNT_W){1'b0}}, r_count} < prfr_pkg::CRC_BITS
                                && bit_val) begin
                            n_crc = r_crc ^ prfr_pkg::CRC_TAB[r_count[3:0]];
                        end
                        n_count = r_count + CNT_W'(1);
                        if (r_count == CNT_W'(FRAME_BITS - 1)) begin
                            cg = n_crc == n_bytes[7:0];
                            ag = n_bytes[23:16] == r_dev_addr;
                            if (cg && ag) begin
                                if (n_bytes[15:8] == prfr_pkg::CMD_ONE) begin
                                    n_out1 = !r_out1;
                                end else if (n_bytes[15:8] == prfr_pkg::CMD_TWO) begin
                                    n_out2 = !r_out2;
                                end
                            end
                            n_out_valid                  = 1'b1;
                            n_out_data.frame_address     = n_bytes[23:16];
                            n_out_data.frame_command     = n_bytes[15:8];
                            n_out_data.frame_check       = n_bytes[7:0];
                            n_out_data.crc_good          = cg;
                            n_out_data.address_good      = ag;
                            n_out_data.output_one_level  = n_out1;
                            n_out_data.output_two_level  = n_out2;
                            n_phase = prfr_pkg::PH_PREAMBLE;
                            n_prev  = 1'b0;
                            n_start = 4'd0;
                            n_count = '0;
                        end
                    end
                    prfr_pkg::PH_STOP: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= prfr_pkg::PH_PREAMBLE;
            r_prev      <= 1'b0;
            r_start     <= 4'd0;
            r_count     <= '0;
            r_crc       <= 8'h00;
            r_out1      <= 1'b0;
            r_out2      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_start     <= n_start;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_out1      <= n_out1;
            r_out2      <= n_out2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes    <= n_bytes;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= prfr_pkg::DEV_ADDR_RESET;
            r_ratio    <= prfr_pkg::RATIO_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (prfr_pkg::t_cfg_idx'(i_cfg_idx))
                prfr_pkg::CFG_DEVICE_ADDRESS: r_dev_addr <= i_cfg_wdata;
                prfr_pkg::CFG_RATIO_LIMIT:    r_ratio    <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/prfr_checker.sv
// ----------------------------------------------------------------------------
// prfr_checker
// Port-level checks on the pulse ratio frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prfr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire prfr_pkg::t_out_item             o_out_data
);

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result slot empty");

    a_result_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_in_valid && o_in_ready) && !$past(o_out_valid) |-> !o_out_valid)
        else $error("result without an accepted request");

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind pulse_ratio_frame_receiver_unit prfr_checker u_prfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
